/* rtl/gsp_pkg.sv */
`default_nettype none

package gsp_pkg;

	localparam int TX_DEPTH_DEF = 8;
	localparam int RX_DEPTH_DEF = 8;
	localparam int REPLY_MAX    = 8;

	// access kinds
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// register window offsets
	localparam logic [3:0] OFF_DATA   = 4'd0;
	localparam logic [3:0] OFF_STATUS = 4'd4;
	localparam logic [3:0] OFF_MODE   = 4'd8;
	localparam logic [3:0] OFF_CTRL   = 4'd10;

	// configuration register byte addresses
	localparam logic [2:0] CFG_CARD_PRESENT = 3'd0;

	// control bits
	localparam int CTRL_EN_BIT   = 0;
	localparam int CTRL_SLOT_BIT = 2;
	localparam int CTRL_ACK_BIT  = 4;
	localparam int CTRL_RST_BIT  = 5;

	// status bits and masks
	localparam int         STAT_TX_BIT   = 0;
	localparam int         STAT_RX_BIT   = 1;
	localparam logic [7:0] STAT_KEEP     = 8'h07;
	localparam logic [7:0] STAT_TAKE     = 8'hF8;
	localparam logic [7:0] STAT_RESET    = 8'h02;

	// reply bytes
	localparam logic [7:0] PAD_CMD_MASK  = 8'h5F;
	localparam logic [7:0] PAD_CMD_POLL0 = 8'h40;
	localparam logic [7:0] PAD_CMD_POLL1 = 8'h41;
	localparam logic [7:0] PAD_CMD_ZERO2 = 8'h42;
	localparam logic [7:0] PAD_CMD_ZERO4 = 8'h43;
	localparam logic [7:0] PAD_ID        = 8'h41;
	localparam logic [7:0] BYTE_ACK      = 8'h5A;
	localparam logic [7:0] CARD_CMD_ID   = 8'h53;
	localparam logic [7:0] CARD_ID_FLAG  = 8'h80;
	localparam logic [7:0] BYTE_NONE     = 8'hFF;

	typedef struct packed {
		logic        func;
		logic [3:0]  offset;
		logic [7:0]  write_data;
		logic [15:0] button_state;
	} req_t;

	typedef struct packed {
		logic [REPLY_MAX-1:0][7:0] bytes;  // entry 0 in the low bits
		logic [3:0]                len;
	} reply_t;

	function automatic reply_t pad_reply(input logic [7:0] cmd, input logic [15:0] buttons);
		reply_t r;
		r.bytes    = '0;
		r.bytes[0] = BYTE_NONE;
		r.bytes[1] = BYTE_NONE;
		r.len      = 4'd2;
		unique case (cmd & PAD_CMD_MASK)
			PAD_CMD_POLL0, PAD_CMD_POLL1: begin
				r.bytes[0] = PAD_ID;
				r.bytes[1] = BYTE_ACK;
				r.bytes[2] = buttons[7:0];
				r.bytes[3] = buttons[15:8];
				r.len      = 4'd4;
			end
			PAD_CMD_ZERO2: begin
				r.bytes[0] = 8'h00;
				r.bytes[1] = 8'h00;
			end
			PAD_CMD_ZERO4: begin
				r.bytes[0] = 8'h00;
				r.bytes[1] = 8'h00;
				r.len      = 4'd4;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic reply_t card_reply(input logic [7:0] cmd, input logic present);
		reply_t r;
		r.bytes = '0;
		r.len   = 4'd1;
		if (!present) begin
			r.bytes[0] = BYTE_NONE;
		end else if (cmd == CARD_CMD_ID) begin
			r.bytes[0] = BYTE_ACK;
			r.bytes[1] = BYTE_ACK;
			r.bytes[4] = CARD_ID_FLAG;
			r.len      = 4'd8;
		end else begin
			r.bytes[0] = BYTE_ACK;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/gamepad_serial_port_registers_unit.sv */
// Controller port register window: gamepad and memory card serial port.
//
// Channels:
//   s_axis_*  one bus access per transfer. tuser carries the access kind
//             (0 read, 1 write); tdata carries offset, write byte and the
//             current pad button bits.
//   m_axis_*  one result per access: the byte read, 0 for writes, FF for an
//             unmapped offset or an empty receive store.
//   APB       card_present at byte address 0; write it only while idle.
// Path: an accepted access is held in the input register, and its result
// is then loaded into the result register, which drives m_axis_tvalid.
// Throughput is one access per cycle while m_axis_tready does not stall
// the result register: the whole register update is a single pass of
// logic between the input register and the result register.
// Stall: while a result waits on m_axis_tready the input register still
// takes one more access; s_axis_tready drops only when both registers are
// full. No access is lost or repeated.
// Reset: arst_n clears all control state at once; status reads 0x02, the
// queues are empty, and the gamepad slot is selected. No clearing pass.
`default_nettype none

module gamepad_serial_port_registers_unit
	import gsp_pkg::*;
#(
	parameter int TX_DEPTH = TX_DEPTH_DEF,
	parameter int RX_DEPTH = RX_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// access in
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [3:0] offset, [11:4] write_data,
	                                         // [27:12] button_state, [31:28] zero
	input  wire logic        s_axis_tuser,  // [0] func
	// result out
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] read_data
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic       valid_s1;
	req_t       req_s1;
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_free;
	logic       fire;
	logic       card_present;
	logic [7:0] core_rdata;

	// the result register can load when empty or being drained this cycle
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1.func         <= s_axis_tuser;
			req_s1.offset       <= s_axis_tdata[3:0];
			req_s1.write_data   <= s_axis_tdata[11:4];
			req_s1.button_state <= s_axis_tdata[27:12];
		end
	end

	gsp_apb u_apb (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.card_present (card_present)
	);

	gsp_core #(
		.TX_DEPTH (TX_DEPTH),
		.RX_DEPTH (RX_DEPTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.req          (req_s1),
		.card_present (card_present),
		.read_data    (core_rdata)
	);

	// result register: hold while stalled, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= core_rdata;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled while a register was free");

endmodule

`default_nettype wire

/* rtl/gsp_apb.sv */
`default_nettype none

module gsp_apb
	import gsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic             card_present
);

	logic card_present_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card_present_q <= 1'b0;
		end else if (wr_en && (paddr == CFG_CARD_PRESENT)) begin
			card_present_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == CFG_CARD_PRESENT) begin
			prdata = {31'd0, card_present_q};
		end
	end

	assign card_present = card_present_q;

endmodule

`default_nettype wire

/* rtl/gsp_core.sv */
`default_nettype none

module gsp_core
	import gsp_pkg::*;
#(
	parameter int TX_DEPTH = TX_DEPTH_DEF,
	parameter int RX_DEPTH = RX_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire req_t       req,
	input  wire logic       card_present,
	output logic [7:0]      read_data
);

	localparam int TXC_W = $clog2(TX_DEPTH + 1);
	localparam int RXC_W = $clog2(RX_DEPTH + 1);
	localparam int RXI_W = $clog2(RX_DEPTH);

	logic [7:0]       tx_first_q, tx_first_d;
	logic [TXC_W-1:0] tx_count_q, tx_count_d;
	logic [RXC_W-1:0] rx_count_q, rx_count_d;
	logic [RXC_W-1:0] rx_ptr_q, rx_ptr_d;
	logic [7:0]       status_q, status_d;
	logic [7:0]       mode_q, mode_d;
	logic [7:0]       ctrl_q, ctrl_d;
	logic             slot_q, slot_d;
	logic [7:0]       rx_store_q [RX_DEPTH];

	logic             slot_new;
	logic             load_reply;
	reply_t           reply;

	assign slot_new = req.write_data[CTRL_SLOT_BIT];
	assign reply    = slot_new ? card_reply(tx_first_q, card_present)
	                           : pad_reply(tx_first_q, req.button_state);

	always_comb begin
		tx_first_d = tx_first_q;
		tx_count_d = tx_count_q;
		rx_count_d = rx_count_q;
		rx_ptr_d   = rx_ptr_q;
		status_d   = status_q;
		mode_d     = mode_q;
		ctrl_d     = ctrl_q;
		slot_d     = slot_q;
		load_reply = 1'b0;
		read_data  = 8'h00;
		if (req.func == FUNC_WRITE) begin
			unique case (req.offset)
				OFF_DATA: begin
					if (tx_count_q < TXC_W'(TX_DEPTH)) begin
						if (tx_count_q == '0) begin
							tx_first_d = req.write_data;
						end
						tx_count_d = tx_count_q + TXC_W'(1);
					end
				end
				OFF_STATUS: begin
					status_d = (status_q & STAT_KEEP) | (req.write_data & STAT_TAKE);
				end
				OFF_MODE: begin
					mode_d = req.write_data;
				end
				OFF_CTRL: begin
					ctrl_d = req.write_data;
					if (req.write_data[CTRL_ACK_BIT] || req.write_data[CTRL_RST_BIT]) begin
						rx_count_d = '0;
						rx_ptr_d   = '0;
					end
					// reset bit is self-clearing
					ctrl_d[CTRL_RST_BIT] = 1'b0;
					if (req.write_data[CTRL_EN_BIT]) begin
						slot_d = slot_new;
						if (tx_count_q != '0) begin
							tx_count_d              = '0;
							load_reply              = 1'b1;
							rx_count_d              = RXC_W'(reply.len);
							rx_ptr_d                = '0;
							status_d[STAT_RX_BIT]   = 1'b1;
							status_d[STAT_TX_BIT]   = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end else begin
			unique case (req.offset)
				OFF_DATA: begin
					if (rx_ptr_q < rx_count_q) begin
						read_data = rx_store_q[rx_ptr_q[RXI_W-1:0]];
						rx_ptr_d  = rx_ptr_q + RXC_W'(1);
						if (rx_ptr_d >= rx_count_q) begin
							status_d[STAT_RX_BIT] = 1'b0;
						end
					end else begin
						read_data = BYTE_NONE;
					end
				end
				OFF_STATUS: read_data = status_q;
				OFF_MODE:   read_data = mode_q;
				OFF_CTRL:   read_data = ctrl_q;
				default:    read_data = BYTE_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_first_q <= '0;
			tx_count_q <= '0;
			rx_count_q <= '0;
			rx_ptr_q   <= '0;
			status_q   <= STAT_RESET;
			mode_q     <= '0;
			ctrl_q     <= '0;
			slot_q     <= 1'b0;
		end else if (fire) begin
			tx_first_q <= tx_first_d;
			tx_count_q <= tx_count_d;
			rx_count_q <= rx_count_d;
			rx_ptr_q   <= rx_ptr_d;
			status_q   <= status_d;
			mode_q     <= mode_d;
			ctrl_q     <= ctrl_d;
			slot_q     <= slot_d;
		end
	end

	// reply bytes past the reply length keep their old contents
	always_ff @(posedge clk) begin
		if (fire && load_reply) begin
			for (int i = 0; i < REPLY_MAX; i++) begin
				if (4'(i) < reply.len) begin
					rx_store_q[i] <= reply.bytes[i];
				end
			end
		end
	end

	a_rx_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx_ptr_q <= rx_count_q)
		else $error("receive read pointer passed the reply length");

	a_tx_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_count_q <= TXC_W'(TX_DEPTH))
		else $error("transmit count beyond depth");

	a_reply_clears_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && load_reply) |=> (tx_count_q == '0) && status_q[STAT_RX_BIT])
		else $error("reply load did not flush transmit queue");

endmodule

`default_nettype wire
